FILE: rtl/pba_pkg.sv
// Shared types, constants and control encodings for the page bitmap allocator.
package pba_pkg;

	// Page and map geometry that does not vary with the pool size.
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_BITS  = 64;
	localparam int BIT_SEL    = 6;
	localparam int CNT_BITS   = 11;
	localparam int ADDR_BITS  = 64;

	localparam logic [PAGE_SHIFT-1:0] PAGE_OFFSET_MASK = 12'hFFF;
	localparam logic [BIT_SEL-1:0]    BIT_MASK         = 6'h3F;

	// Request kinds carried in the req_type field.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic                  req_type;
		logic [CNT_BITS-1:0]   page_count;
		logic [ADDR_BITS-1:0]  page_address;
	} req_t;

	typedef struct packed {
		logic                  ok;
		logic [ADDR_BITS-1:0]  run_address;
		logic [CNT_BITS-1:0]   pages_left;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_MARK_RD,
		ST_MARK,
		ST_FREE_WR,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic scan_start;
		logic scan_next;
		logic hit_take;
		logic mark_rd;
		logic mark_wr;
		logic mark_next;
		logic mark_done;
		logic free_rd;
		logic free_wr;
		logic res_fail;
		logic rsp_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic req_free;
		logic alloc_ok;
		logic free_ok;
		logic hit;
		logic scan_last;
		logic mark_last;
		logic rsp_free;
	} sts_t;

endpackage

FILE: rtl/page_bitmap_allocator_core.sv
// Top level of the page bitmap allocator: first-fit page runs over a one-bit-per-page map.
//
// Channel   Direction  Handshake            Beat
// req       in         req_valid/req_ready  req_t: req_type, page_count, page_address
// rsp       out        rsp_valid/rsp_ready  rsp_t: ok, run_address, pages_left
// cfg       in         cfg_we               cfg_wdata: pool_base
//
// One request is worked at a time. The map is kept as 64-page words in a RAM with one
// read and one write port; the run search examines one word per cycle, and marking
// rewrites one word per cycle. A granted allocation scans W words and marks M words,
// each at most ceil(POOL_PAGES/64); one that finds no run scans W, and a free reads and
// rewrites one word. After reset the map is swept once over all ceil(POOL_PAGES/64)
// words to load the reserved head, with req_ready low. A new request is accepted while
// the previous response still waits in the output register; the next one holds in its
// last cycle until that beat is taken.
module page_bitmap_allocator_core import pba_pkg::*; #(
	parameter int POOL_PAGES     = 1024,
	parameter int RESERVED_PAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [ADDR_BITS-1:0] cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	pba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Map storage and arithmetic.
	pba_dp #(
		.POOL_PAGES     (POOL_PAGES),
		.RESERVED_PAGES (RESERVED_PAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/pba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/pba_ctrl.sv
// Controller state machine that sequences clearing, scanning, marking and freeing.
module pba_ctrl import pba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register; reset starts the clearing pass over the map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.req_free) begin
					state_nxt = sts.free_ok ? ST_FREE_WR : ST_DONE;
				end else begin
					state_nxt = sts.alloc_ok ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					state_nxt = ST_MARK_RD;
				end else if (sts.scan_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_MARK_RD: begin
				state_nxt = ST_MARK;
			end
			ST_MARK: begin
				if (sts.mark_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_FREE_WR: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (sts.rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_DECODE: begin
				if (sts.req_free) begin
					cmd.free_rd  = sts.free_ok;
					cmd.res_fail = !sts.free_ok;
				end else begin
					cmd.scan_start = sts.alloc_ok;
					cmd.res_fail   = !sts.alloc_ok;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.hit_take = 1'b1;
				end else if (sts.scan_last) begin
					cmd.res_fail = 1'b1;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_MARK_RD: begin
				cmd.mark_rd = 1'b1;
			end
			ST_MARK: begin
				cmd.mark_wr   = 1'b1;
				cmd.mark_done = sts.mark_last;
				cmd.mark_next = !sts.mark_last;
			end
			ST_FREE_WR: begin
				cmd.free_wr = 1'b1;
			end
			ST_DONE: begin
				cmd.rsp_load = sts.rsp_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/pba_dp.sv
// Datapath: use map RAM, run search over one map word, marking, freeing and result register.
module pba_dp import pba_pkg::*; #(
	parameter int POOL_PAGES     = 1024,
	parameter int RESERVED_PAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [ADDR_BITS-1:0] cfg_wdata,
	input  req_t                 req,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	output rsp_t                 rsp
);

	localparam int WORDS    = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int GW       = AW + BIT_SEL;
	localparam int CW       = $clog2(POOL_PAGES + 1);
	localparam int MW       = (CW > CNT_BITS) ? CW : CNT_BITS;
	localparam int PN       = ADDR_BITS - PAGE_SHIFT;
	localparam int RSV      = (RESERVED_PAGES > POOL_PAGES) ? POOL_PAGES : RESERVED_PAGES;
	localparam int RSV_WORD = RSV / WORD_BITS;
	localparam int RSV_REM  = RSV % WORD_BITS;
	localparam int LAST_REM = POOL_PAGES % WORD_BITS;
	localparam int LW       = BIT_SEL + 1;
	localparam int SUMW     = CNT_BITS + 1;

	localparam logic [WORD_BITS-1:0] RSV_MASK  = (WORD_BITS'(1) << RSV_REM) - WORD_BITS'(1);
	localparam logic [WORD_BITS-1:0] LAST_MASK = (LAST_REM == 0) ? {WORD_BITS{1'b1}} :
		((WORD_BITS'(1) << LAST_REM) - WORD_BITS'(1));
	localparam logic [CW-1:0]        FREE_INIT = CW'(POOL_PAGES - RSV);
	localparam logic [AW-1:0]        LAST_WORD = AW'(WORDS - 1);

	// Configuration and request registers.
	logic [ADDR_BITS-1:0] pool_base_q;
	logic                 req_type_q;
	logic [CNT_BITS-1:0]  want_q;
	logic [ADDR_BITS-1:0] offset_q;
	logic                 aligned_q;

	// Control state.
	logic [CW-1:0]        free_cnt_q;
	logic [AW-1:0]        clr_idx_q;
	logic [AW-1:0]        scan_idx_q;
	logic [CNT_BITS-1:0]  run_q;
	logic [GW-1:0]        start_q;
	logic [GW-1:0]        end_q;
	logic [AW-1:0]        mk_idx_q;
	logic                 res_ok_q;
	logic [ADDR_BITS-1:0] res_addr_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// RAM port signals.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// Combinational helpers.
	logic [WORD_BITS-1:0] init_word;
	logic [WORD_BITS-1:0] free_bits;
	logic [LW-1:0]        run_len [BIT_SEL+1][WORD_BITS];
	logic [WORD_BITS-1:0] hit_vec;
	logic [BIT_SEL-1:0]   hit_pos;
	logic [GW-1:0]        hit_start;
	logic [LW-1:0]        top_len;
	logic [CNT_BITS-1:0]  run_nxt;
	logic [WORD_BITS-1:0] mk_lo;
	logic [WORD_BITS-1:0] mk_hi;
	logic [GW-1:0]        fpage;
	logic [AW-1:0]        fword;
	logic [BIT_SEL-1:0]   fbit;
	logic                 fold;

	pba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Reset contents of a map word: reserved head pages are in use.
	always_comb begin
		if (int'(clr_idx_q) < RSV_WORD) begin
			init_word = {WORD_BITS{1'b1}};
		end else if (int'(clr_idx_q) == RSV_WORD) begin
			init_word = RSV_MASK;
		end else begin
			init_word = '0;
		end
	end

	// Free page slot named by the latched offset.
	assign fpage = offset_q[PAGE_SHIFT +: GW];
	assign fword = fpage[GW-1:BIT_SEL];
	assign fbit  = fpage[BIT_SEL-1:0];
	assign fold  = ram_rdata[fbit];

	// Free bits of the word under scan; pages past the pool end count as used.
	assign free_bits = ~ram_rdata & ((scan_idx_q == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}});

	// Length of the free run ending at each bit, by a segmented prefix scan.
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			run_len[0][j] = LW'(free_bits[j]);
		end
		for (int lv = 0; lv < BIT_SEL; lv++) begin
			for (int j = 0; j < WORD_BITS; j++) begin
				run_len[lv+1][j] = run_len[lv][j];
			end
			for (int j = (1 << lv); j < WORD_BITS; j++) begin
				if (run_len[lv][j] == LW'(1 << lv)) begin
					run_len[lv+1][j] = run_len[lv][j] + run_len[lv][j - (1 << lv)];
				end
			end
		end
	end

	// A run is long enough at bit j; a run reaching bit zero extends the carried run.
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			if (run_len[BIT_SEL][j] == LW'(j + 1)) begin
				hit_vec[j] = (SUMW'(run_q) + SUMW'(j + 1)) >= SUMW'(want_q);
			end else begin
				hit_vec[j] = SUMW'(run_len[BIT_SEL][j]) >= SUMW'(want_q);
			end
		end
	end

	// Lowest bit that completes a run.
	always_comb begin
		hit_pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_pos = BIT_SEL'(j);
			end
		end
	end

	assign hit_start = GW'({scan_idx_q, hit_pos}) + GW'(1) - GW'(want_q);
	assign top_len   = run_len[BIT_SEL][WORD_BITS-1];
	assign run_nxt   = (top_len == LW'(WORD_BITS)) ? (run_q + CNT_BITS'(WORD_BITS)) :
		CNT_BITS'(top_len);

	// Bits of the current word that lie in the granted run.
	assign mk_lo = (mk_idx_q == start_q[GW-1:BIT_SEL]) ?
		({WORD_BITS{1'b1}} << start_q[BIT_SEL-1:0]) : {WORD_BITS{1'b1}};
	assign mk_hi = (mk_idx_q == end_q[GW-1:BIT_SEL]) ?
		({WORD_BITS{1'b1}} >> (BIT_MASK - end_q[BIT_SEL-1:0])) : {WORD_BITS{1'b1}};

	// RAM write port select.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fword;
		ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fbit);
		if (cmd.clear_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = init_word;
		end else if (cmd.mark_wr) begin
			ram_we    = 1'b1;
			ram_waddr = mk_idx_q;
			ram_wdata = ram_rdata | (mk_lo & mk_hi);
		end else if (cmd.free_wr) begin
			ram_we    = 1'b1;
		end
	end

	// RAM read port select.
	always_comb begin
		ram_re    = cmd.scan_start | cmd.scan_next | cmd.mark_rd | cmd.mark_next | cmd.free_rd;
		ram_raddr = fword;
		if (cmd.scan_start) begin
			ram_raddr = '0;
		end else if (cmd.scan_next) begin
			ram_raddr = scan_idx_q + AW'(1);
		end else if (cmd.mark_rd) begin
			ram_raddr = start_q[GW-1:BIT_SEL];
		end else if (cmd.mark_next) begin
			ram_raddr = mk_idx_q + AW'(1);
		end
	end

	// Status to the controller.
	always_comb begin
		sts            = '0;
		sts.clear_last = clr_idx_q == LAST_WORD;
		sts.req_free   = req_type_q == REQ_FREE;
		sts.alloc_ok   = (want_q != '0) && (MW'(want_q) <= MW'(free_cnt_q));
		sts.free_ok    = aligned_q && (offset_q[ADDR_BITS-1:PAGE_SHIFT] >= PN'(RSV)) &&
			(offset_q[ADDR_BITS-1:PAGE_SHIFT] < PN'(POOL_PAGES));
		sts.hit        = |hit_vec;
		sts.scan_last  = scan_idx_q == LAST_WORD;
		sts.mark_last  = mk_idx_q == end_q[GW-1:BIT_SEL];
		sts.rsp_free   = !rsp_valid_q || rsp_ready;
	end

	// Pool base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
		end else if (cfg_we) begin
			pool_base_q <= cfg_wdata;
		end
	end

	// Request capture; the free offset is formed once at acceptance.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			want_q     <= req.page_count;
			offset_q   <= req.page_address - pool_base_q;
			aligned_q  <= (req.page_address[PAGE_SHIFT-1:0] & PAGE_OFFSET_MASK) == '0;
		end
	end

	// Clearing sweep index and free page count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			free_cnt_q <= FREE_INIT;
		end else begin
			if (cmd.clear_wr) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (cmd.mark_done) begin
				free_cnt_q <= free_cnt_q - CW'(want_q);
			end else if (cmd.free_wr && fold) begin
				free_cnt_q <= free_cnt_q + CW'(1);
			end
		end
	end

	// Scan position, carried run length, granted run and marking index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			run_q      <= '0;
			start_q    <= '0;
			end_q      <= '0;
			mk_idx_q   <= '0;
		end else begin
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				run_q      <= '0;
			end else if (cmd.scan_next) begin
				scan_idx_q <= scan_idx_q + AW'(1);
				run_q      <= run_nxt;
			end
			if (cmd.hit_take) begin
				start_q <= hit_start;
			end
			if (cmd.mark_rd) begin
				end_q    <= start_q + GW'(want_q) - GW'(1);
				mk_idx_q <= start_q[GW-1:BIT_SEL];
			end else if (cmd.mark_next) begin
				mk_idx_q <= mk_idx_q + AW'(1);
			end
		end
	end

	// Pending result of the request in progress.
	always_ff @(posedge clk) begin
		if (cmd.res_fail) begin
			res_ok_q   <= 1'b0;
			res_addr_q <= '0;
		end else if (cmd.mark_rd) begin
			res_addr_q <= pool_base_q + (ADDR_BITS'(start_q) << PAGE_SHIFT);
		end else if (cmd.mark_done) begin
			res_ok_q   <= 1'b1;
		end else if (cmd.free_wr) begin
			res_ok_q   <= 1'b1;
			res_addr_q <= '0;
		end
	end

	// Output register; holds a beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.ok          <= res_ok_q;
			rsp_q.run_address <= res_addr_q;
			rsp_q.pages_left  <= CNT_BITS'(free_cnt_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
